@@ design/hbbc_pkg.sv @@
// Shared types and constants for the hashed block buffer cache.
// Used by the front end, the queue, the back end and the top level.
package hbbc_pkg;

  localparam int NUM_BUFFERS = 32;
  localparam int NUM_BUCKETS = 13;

  localparam int IDX_W  = $clog2(NUM_BUFFERS);
  localparam int RANK_W = IDX_W;
  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  localparam int DEV_W  = 8;
  localparam int BLK_W  = 32;
  localparam int BIDX_W = 5;
  localparam int CNT_W  = 8;
  localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_UNDER  = 2'd2,
    ST_OVER   = 2'd3
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    logic [BIDX_W-1:0] idx;
    logic [BKT_W-1:0]  key;
  } item_t;

  typedef struct packed {
    logic [BIDX_W-1:0] granted;
    logic              hit;
    logic              disk;
    status_t           status;
  } result_t;

endpackage

@@ design/hashed_block_buffer_cache.sv @@
// Top level of the hashed block buffer cache.
// Depends on hbbc_pkg, hbbc_front, hbbc_queue and hbbc_back.
//
// Usage:
//   Requests enter on the in_ stream: in_tuser carries the operation
//   (read, release, pin, unpin), in_tdata the device, block number and
//   buffer index. Each request yields exactly one transfer on the out_
//   stream: granted index, hit flag, disk-read flag and status.
//   The front end takes a new request only after the last one is pushed; it
//   reduces the block number to its bucket four bits per cycle and pushes the
//   request into a two-entry queue.
//   The back end pops a request and, for a read, walks all 32 entries one
//   per cycle to find the newest tag match, the oldest free entry of the
//   own bucket and the oldest free entry of the lowest other bucket; an
//   update state then updates the entry and loads the result register. A
//   read thus passes through the idle, scan and update states, while
//   release/pin/unpin skip the scan; the entry scan sets the sustained read
//   rate.
//   The result register holds while out_tready is low; the back end then
//   stalls before its update, and the queue and front end keep accepting
//   until the queue is full.
//   Synchronous reset clears all tag-written flags, counts and valid bits, sets each
//   entry's rank to its index and empties the queue and result register.
module hashed_block_buffer_cache
  import hbbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [7:0] device_id, [39:8] block_number,
                                  // [44:40] buffer_index, [47:45] zero
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [4:0] granted_index, [5] was_hit,
                                  // [6] needs_disk_read, [8:7] status, [15:9] zero
);

  item_t   in_item;
  item_t   push_item;
  item_t   pop_item;
  logic    push_valid, push_ready;
  logic    pop_valid, pop_ready;
  result_t res;

  // Unpack the request; the key is filled in by the front end
  always_comb begin
    in_item.op  = op_t'(in_tuser);
    in_item.dev = in_tdata[7:0];
    in_item.blk = in_tdata[39:8];
    in_item.idx = in_tdata[44:40];
    in_item.key = '0;
  end

  hbbc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  hbbc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  hbbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Pack the result, first field in the lowest bits
  assign out_tdata = {7'b0, res.status, res.disk, res.hit, res.granted};

endmodule

@@ design/hbbc_front.sv @@
// Front end: accept a request and reduce its block number to a bucket key.
// Depends on hbbc_pkg; feeds hbbc_queue.
module hbbc_front
  import hbbc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  push_valid,
  input  logic  push_ready,
  output item_t push_item
);

  typedef enum logic [1:0] {F_IDLE, F_RED, F_PUSH} fstate_t;

  fstate_t          state_r;
  item_t            item_r;
  logic [BLK_W-1:0] sh_r;
  logic [2:0]       cnt_r;
  logic [BKT_W-1:0] rem_r;
  logic [BKT_W-1:0] rem_nxt;

  // Fold four bits per cycle into the running remainder, one conditional subtract each.
  always_comb begin
    logic [BKT_W:0] t;
    logic [BKT_W-1:0] r;
    r = rem_r;
    t = '0;
    for (int b = 3; b >= 0; b--) begin
      t = {r, sh_r[BLK_W-4+b]};
      if (t >= (BKT_W+1)'(NUM_BUCKETS)) begin
        t = t - (BKT_W+1)'(NUM_BUCKETS);
      end
      r = t[BKT_W-1:0];
    end
    rem_nxt = r;
  end

  assign in_ready   = (state_r == F_IDLE);
  assign push_valid = (state_r == F_PUSH);

  always_comb begin
    push_item     = item_r;
    push_item.key = rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            item_r  <= in_item;
            sh_r    <= in_item.blk;
            cnt_r   <= '0;
            rem_r   <= '0;
            state_r <= F_RED;
          end
        end
        F_RED: begin
          rem_r <= rem_nxt;
          sh_r  <= {sh_r[BLK_W-5:0], 4'b0};
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

@@ design/hbbc_queue.sv @@
// Two-entry queue between the front end and the back end.
// Depends on hbbc_pkg.
module hbbc_queue
  import hbbc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t      mem_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] fill_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_item   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= 1'b0;
      rd_r   <= 1'b0;
      fill_r <= '0;
    end else begin
      if (do_push) wr_r <= ~wr_r;
      if (do_pop)  rd_r <= ~rd_r;
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

endmodule

@@ design/hbbc_back.sv @@
// Back end: entry store, scan of all entries, update and result register.
// Depends on hbbc_pkg; takes items from hbbc_queue.
module hbbc_back
  import hbbc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    pop_valid,
  output logic    pop_ready,
  input  item_t   pop_item,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  typedef enum logic [1:0] {B_IDLE, B_SCAN, B_ACT} bstate_t;

  // Entry store
  logic [DEV_W-1:0]  dev_m   [NUM_BUFFERS];
  logic [BLK_W-1:0]  blk_m   [NUM_BUFFERS];
  logic [BKT_W-1:0]  bkt_m   [NUM_BUFFERS];
  logic              wrt_r   [NUM_BUFFERS];
  logic              dv_r    [NUM_BUFFERS];
  logic [CNT_W-1:0]  count_r [NUM_BUFFERS];
  logic [RANK_W-1:0] rank_r  [NUM_BUFFERS];

  bstate_t           state_r;
  item_t             item_r;
  logic [IDX_W-1:0]  j_r;
  logic              hit_f_r, own_f_r, oth_f_r;
  logic [IDX_W-1:0]  hit_e_r, own_e_r, oth_e_r;
  logic [RANK_W-1:0] hit_rk_r, own_rk_r, oth_rk_r;
  logic [BKT_W-1:0]  oth_bk_r;
  logic              out_valid_r;
  result_t           out_res_r;

  logic [IDX_W-1:0]  addr;
  logic [DEV_W-1:0]  dev_a;
  logic [BLK_W-1:0]  blk_a;
  logic [BKT_W-1:0]  bkt_a;
  logic [CNT_W-1:0]  cnt_a;
  logic              dv_a;
  logic [RANK_W-1:0] rank_a;
  logic [IDX_W-1:0]  act_e;
  logic              in_range;
  logic              fire;
  logic              cnt_we, dv_we, tag_we, mk_new;
  logic [CNT_W-1:0]  cnt_wd;
  result_t           res;
  logic              m_hit, m_own, m_oth;

  assign in_range  = (32'(item_r.idx) < NUM_BUFFERS);
  assign act_e     = hit_f_r ? hit_e_r : (own_f_r ? own_e_r : oth_e_r);
  assign addr      = (state_r == B_SCAN) ? j_r :
                     ((item_r.op == OP_READ) ? act_e : IDX_W'(item_r.idx));
  assign dev_a     = wrt_r[addr] ? dev_m[addr] : '0;
  assign blk_a     = wrt_r[addr] ? blk_m[addr] : '0;
  assign bkt_a     = wrt_r[addr] ? bkt_m[addr] : '0;
  assign cnt_a     = count_r[addr];
  assign dv_a      = dv_r[addr];
  assign rank_a    = rank_r[addr];
  assign fire      = (state_r == B_ACT) && (!out_valid_r || out_ready);
  assign pop_ready = (state_r == B_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Scan compares for the entry under the cursor
  always_comb begin
    m_hit = (dev_a == item_r.dev) && (blk_a == item_r.blk) &&
            (!hit_f_r || rank_a > hit_rk_r);
    m_own = (cnt_a == '0) && (bkt_a == item_r.key) &&
            (!own_f_r || rank_a < own_rk_r);
    m_oth = (cnt_a == '0) && (bkt_a != item_r.key) &&
            (!oth_f_r || bkt_a < oth_bk_r || (bkt_a == oth_bk_r && rank_a < oth_rk_r));
  end

  // Decide the update and the result of the current item
  always_comb begin
    cnt_we      = 1'b0;
    cnt_wd      = cnt_a;
    dv_we       = 1'b0;
    tag_we      = 1'b0;
    mk_new      = 1'b0;
    res.granted = item_r.idx;
    res.hit     = 1'b0;
    res.disk    = 1'b0;
    res.status  = ST_OK;
    if (item_r.op == OP_READ) begin
      res.granted = '0;
      if (hit_f_r) begin
        res.granted = BIDX_W'(act_e);
        res.hit     = 1'b1;
        if (cnt_a == COUNT_MAX) begin
          res.status = ST_OVER;
        end else begin
          cnt_we = 1'b1;
          cnt_wd = cnt_a + CNT_W'(1);
          if (!dv_a) begin
            res.disk = 1'b1;
            dv_we    = 1'b1;
          end
        end
      end else if (own_f_r || oth_f_r) begin
        res.granted = BIDX_W'(act_e);
        res.disk    = 1'b1;
        tag_we      = 1'b1;
        cnt_we      = 1'b1;
        cnt_wd      = CNT_W'(1);
        dv_we       = 1'b1;
        mk_new      = !own_f_r;
      end else begin
        res.status = ST_NOFREE;
      end
    end else if (in_range) begin
      if (item_r.op == OP_PIN) begin
        if (cnt_a == COUNT_MAX) begin
          res.status = ST_OVER;
        end else begin
          cnt_we = 1'b1;
          cnt_wd = cnt_a + CNT_W'(1);
        end
      end else if (cnt_a == '0) begin
        res.status = ST_UNDER;
      end else begin
        cnt_we = 1'b1;
        cnt_wd = cnt_a - CNT_W'(1);
        mk_new = (item_r.op == OP_RELEASE) && (cnt_a == CNT_W'(1));
      end
    end
  end

  // Tag store, written only on allocation
  always_ff @(posedge clk) begin
    if (fire && tag_we) begin
      dev_m[act_e] <= item_r.dev;
      blk_m[act_e] <= item_r.blk;
      bkt_m[act_e] <= item_r.key;
    end
  end

  // Per-entry control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_BUFFERS; k++) begin
        wrt_r[k]   <= 1'b0;
        dv_r[k]    <= 1'b0;
        count_r[k] <= '0;
        rank_r[k]  <= RANK_W'(k);
      end
    end else if (fire) begin
      if (tag_we) wrt_r[addr] <= 1'b1;
      if (dv_we)  dv_r[addr] <= 1'b1;
      if (cnt_we) count_r[addr] <= cnt_wd;
      if (mk_new) begin
        for (int k = 0; k < NUM_BUFFERS; k++) begin
          if (IDX_W'(k) == addr) begin
            rank_r[k] <= RANK_W'(NUM_BUFFERS-1);
          end else if (rank_r[k] > rank_a) begin
            rank_r[k] <= rank_r[k] - RANK_W'(1);
          end
        end
      end
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (pop_valid) begin
            item_r  <= pop_item;
            j_r     <= '0;
            hit_f_r <= 1'b0;
            own_f_r <= 1'b0;
            oth_f_r <= 1'b0;
            state_r <= (pop_item.op == OP_READ) ? B_SCAN : B_ACT;
          end
        end
        B_SCAN: begin
          if (m_hit) begin
            hit_f_r  <= 1'b1;
            hit_e_r  <= j_r;
            hit_rk_r <= rank_a;
          end
          if (m_own) begin
            own_f_r  <= 1'b1;
            own_e_r  <= j_r;
            own_rk_r <= rank_a;
          end
          if (m_oth) begin
            oth_f_r  <= 1'b1;
            oth_e_r  <= j_r;
            oth_rk_r <= rank_a;
            oth_bk_r <= bkt_a;
          end
          j_r <= j_r + IDX_W'(1);
          if (j_r == IDX_W'(NUM_BUFFERS-1)) begin
            state_r <= B_ACT;
          end
        end
        B_ACT: begin
          if (fire) begin
            out_valid_r <= 1'b1;
            out_res_r   <= res;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule
